FILE: sv/spcr_pkg.sv
package spcr_pkg;

  localparam int FIELD_W    = 24;
  localparam int DIFF_W     = FIELD_W + 1;
  localparam int RADIUS_W   = 20;
  localparam int COEFF_W    = 17;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RST      = 20'd13107;
  localparam logic [COEFF_W-1:0]  RESTITUTION_RST = 17'd62259;
  localparam logic [COEFF_W-1:0]  CORRECTION_RST  = 17'd13107;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS      = 2'd0,
    CFG_RESTITUTION = 2'd1,
    CFG_CORRECTION  = 2'd2
  } cfg_idx_e;

  typedef logic [2:0][FIELD_W-1:0] vec3_t;
  typedef logic [2:0][DIFF_W-1:0]  dvec_t;

  typedef struct packed {
    vec3_t p1;
    vec3_t v1;
    vec3_t p2;
    vec3_t v2;
  } pair_t;

  typedef struct packed {
    logic  collided;
    vec3_t pos;
    vec3_t vel;
  } res_t;

endpackage

FILE: sv/spcr_in_if.sv
interface spcr_in_if import spcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] first_pos_x;
  logic signed [FIELD_W-1:0] first_pos_y;
  logic signed [FIELD_W-1:0] first_pos_z;
  logic signed [FIELD_W-1:0] first_vel_x;
  logic signed [FIELD_W-1:0] first_vel_y;
  logic signed [FIELD_W-1:0] first_vel_z;
  logic signed [FIELD_W-1:0] second_pos_x;
  logic signed [FIELD_W-1:0] second_pos_y;
  logic signed [FIELD_W-1:0] second_pos_z;
  logic signed [FIELD_W-1:0] second_vel_x;
  logic signed [FIELD_W-1:0] second_vel_y;
  logic signed [FIELD_W-1:0] second_vel_z;

  modport source (
    output valid, first_pos_x, first_pos_y, first_pos_z,
    output first_vel_x, first_vel_y, first_vel_z,
    output second_pos_x, second_pos_y, second_pos_z,
    output second_vel_x, second_vel_y, second_vel_z,
    input  ready
  );

  modport sink (
    input  valid, first_pos_x, first_pos_y, first_pos_z,
    input  first_vel_x, first_vel_y, first_vel_z,
    input  second_pos_x, second_pos_y, second_pos_z,
    input  second_vel_x, second_vel_y, second_vel_z,
    output ready
  );
endinterface

FILE: sv/spcr_out_if.sv
interface spcr_out_if import spcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      which_sphere;
  logic                      last_of_pair;
  logic                      collided;
  logic signed [FIELD_W-1:0] new_pos_x;
  logic signed [FIELD_W-1:0] new_pos_y;
  logic signed [FIELD_W-1:0] new_pos_z;
  logic signed [FIELD_W-1:0] new_vel_x;
  logic signed [FIELD_W-1:0] new_vel_y;
  logic signed [FIELD_W-1:0] new_vel_z;

  modport source (
    output valid, which_sphere, last_of_pair, collided,
    output new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );

  modport sink (
    input  valid, which_sphere, last_of_pair, collided,
    input  new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

FILE: sv/sphere_pair_collision_resolve.sv
// Collision response for a pair of equal-mass spheres. Each input word holds both
// spheres' positions and velocities in signed fixed point; each pair gives two
// output words, first sphere then second, with positions pushed apart and velocities
// exchanged along the contact normal when the spheres overlap, saturated to 24 bits.
// The datapath is a single stall-as-a-whole pipeline: three input stages, a
// square-root pipeline of one result bit per stage (25), an overlap-test stage, a
// normal-velocity divider of one quotient bit per stage (27), three multiply stages,
// a six-lane divider of FRAC_BITS-derived depth (28 at FRAC_BITS = 16) and an output
// register. The output port, carrying two words per pair, sets the rate: a new pair
// is taken only when the output register is empty or its second word is being taken.
// Configuration is written through a plain write port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module sphere_pair_collision_resolve
  import spcr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  spcr_in_if.sink               pair_i,
  spcr_out_if.source            result_o
);

  localparam int SQ_W    = 2 * DIFF_W - 2;
  localparam int PR_W    = 2 * DIFF_W;
  localparam int RAD_W   = 2 * DIFF_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DOT_W   = RAD_W + 1;
  localparam int VN_W    = DIFF_W + 2;
  localparam int DEP_W   = RADIUS_W + 1;
  localparam int CD_W    = COEFF_W + DEP_W;
  localparam int CD_LO_W = CD_W / 2;
  localparam int CD_HI_W = CD_W - CD_LO_W;
  localparam int MAG_W   = FIELD_W;
  localparam int KW      = ((FRAC_BITS > COEFF_W) ? FRAC_BITS : COEFF_W) + 1;
  localparam int HP_W    = VN_W + KW;
  localparam int HW      = HP_W - FRAC_BITS - 1;
  localparam int SP_W    = MAG_W + CD_W;
  localparam int DN_W    = HW + MAG_W;
  localparam int OW      = ((HW + 1 > FIELD_W) ? HW + 1 : FIELD_W) + 1;

  localparam logic signed [OW-1:0] SAT_HI = OW'((1 << (FIELD_W - 1)) - 1);
  localparam logic signed [OW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    pair_t             pv;
    dvec_t             d;
    logic [DOT_W-1:0]  dot;
    logic              nz;
  } sq_side_t;

  typedef struct packed {
    pair_t             pv;
    dvec_t             d;
    logic              hit;
    logic              neg;
    logic [DEP_W-1:0]  depth;
  } vn_side_t;

  typedef struct packed {
    pair_t       pv;
    logic [2:0]  dsgn;
    logic        hit;
    logic        neg;
  } dv_side_t;

  function automatic logic [FIELD_W-1:0] sat(input logic signed [OW-1:0] v);
    logic [FIELD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[FIELD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[FIELD_W-1:0];
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [RADIUS_W-1:0] radius_q;
  logic [COEFF_W-1:0]  rest_q;
  logic [COEFF_W-1:0]  corr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      rest_q   <= RESTITUTION_RST;
      corr_q   <= CORRECTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS:      radius_q <= cfg_wdata_i[RADIUS_W-1:0];
        CFG_RESTITUTION: rest_q   <= cfg_wdata_i[COEFF_W-1:0];
        CFG_CORRECTION:  corr_q   <= cfg_wdata_i[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;

  // stage 1: offsets
  pair_t in_pv;
  dvec_t in_d, in_dv;

  always_comb begin
    in_pv.p1[0] = pair_i.first_pos_x;
    in_pv.p1[1] = pair_i.first_pos_y;
    in_pv.p1[2] = pair_i.first_pos_z;
    in_pv.v1[0] = pair_i.first_vel_x;
    in_pv.v1[1] = pair_i.first_vel_y;
    in_pv.v1[2] = pair_i.first_vel_z;
    in_pv.p2[0] = pair_i.second_pos_x;
    in_pv.p2[1] = pair_i.second_pos_y;
    in_pv.p2[2] = pair_i.second_pos_z;
    in_pv.v2[0] = pair_i.second_vel_x;
    in_pv.v2[1] = pair_i.second_vel_y;
    in_pv.v2[2] = pair_i.second_vel_z;
    for (int i = 0; i < 3; i++) begin
      in_d[i]  = DIFF_W'($signed(in_pv.p2[i])) - DIFF_W'($signed(in_pv.p1[i]));
      in_dv[i] = DIFF_W'($signed(in_pv.v2[i])) - DIFF_W'($signed(in_pv.v1[i]));
    end
  end

  logic  s1_vld_q;
  pair_t s1_pv_q;
  dvec_t s1_d_q, s1_dv_q;

  // stage 2: products
  logic [2:0][SQ_W-1:0] s2_sq_d, s2_sq_q;
  logic [2:0][PR_W-1:0] s2_pr_d, s2_pr_q;
  logic                 s2_vld_q, s2_nz_q;
  pair_t                s2_pv_q;
  dvec_t                s2_d_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [PR_W-1:0] sq_full;
      sq_full    = $signed(s1_d_q[i]) * $signed(s1_d_q[i]);
      s2_sq_d[i] = sq_full[SQ_W-1:0];
      s2_pr_d[i] = $signed(s1_dv_q[i]) * $signed(s1_d_q[i]);
    end
  end

  // stage 3: sums
  logic             s3_vld_q;
  logic [RAD_W-1:0] s3_rad_d, s3_rad_q;
  sq_side_t         s3_side_d, s3_side_q;

  always_comb begin
    s3_rad_d      = RAD_W'(s2_sq_q[0]) + RAD_W'(s2_sq_q[1]) + RAD_W'(s2_sq_q[2]);
    s3_side_d.pv  = s2_pv_q;
    s3_side_d.d   = s2_d_q;
    s3_side_d.nz  = s2_nz_q;
    s3_side_d.dot = DOT_W'($signed(s2_pr_q[0])) + DOT_W'($signed(s2_pr_q[1]))
                  + DOT_W'($signed(s2_pr_q[2]));
  end

  logic              iq_vld;
  logic [ROOT_W-1:0] iq_root;
  sq_side_t          iq_side;

  spcr_isqrt #(
    .RW (RAD_W),
    .SW ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (iq_vld),
    .root_o  (iq_root),
    .side_o  (iq_side)
  );

  // stage 4: overlap test, dot magnitude
  logic              s4_vld_q;
  logic [RAD_W-1:0]  s4_mag_d, s4_mag_q;
  logic [ROOT_W-1:0] s4_dist_q;
  vn_side_t          s4_side_d, s4_side_q;

  always_comb begin
    logic [ROOT_W:0]  two_r;
    logic [ROOT_W:0]  depth_full;
    logic [DOT_W-1:0] dot_abs;
    two_r            = (ROOT_W + 1)'({radius_q, 1'b0});
    depth_full       = two_r - {1'b0, iq_root};
    s4_side_d.pv     = iq_side.pv;
    s4_side_d.d      = iq_side.d;
    s4_side_d.hit    = iq_side.nz && !depth_full[ROOT_W] && (depth_full != '0);
    s4_side_d.neg    = iq_side.dot[DOT_W-1];
    s4_side_d.depth  = depth_full[DEP_W-1:0];
    dot_abs          = s4_side_d.neg ? -iq_side.dot : iq_side.dot;
    s4_mag_d         = dot_abs[RAD_W-1:0];
  end

  logic                  vd_vld;
  logic [0:0][VN_W-1:0]  vd_quo;
  logic [ROOT_W-1:0]     vd_dist;
  vn_side_t              vd_side;

  spcr_div #(
    .NW    (RAD_W),
    .DW    (ROOT_W),
    .QW    (VN_W),
    .LANES (1),
    .SW    ($bits(vn_side_t))
  ) u_vn_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_vld_q),
    .num_i   (s4_mag_q),
    .den_i   (s4_dist_q),
    .side_i  (s4_side_q),
    .valid_o (vd_vld),
    .quo_o   (vd_quo),
    .den_o   (vd_dist),
    .side_o  (vd_side)
  );

  // stage 5: correction depth and restitution products
  logic              s5_vld_q;
  logic [CD_W-1:0]   s5_cd_d, s5_cd_q;
  logic [HP_W-1:0]   s5_hp_d, s5_hp_q;
  logic [ROOT_W-1:0] s5_dist_q;
  vn_side_t          s5_side_q;

  always_comb begin
    logic [KW-1:0] k;
    k       = (KW'(1) << FRAC_BITS) + KW'(rest_q);
    s5_cd_d = CD_W'(corr_q) * CD_W'(vd_side.depth);
    s5_hp_d = HP_W'(vd_quo[0]) * HP_W'(k);
  end

  // stage 6: half impulse, partial products of the push
  logic                               s6_vld_q;
  logic [HW-1:0]                      s6_half_q;
  logic [2:0][MAG_W-1:0]              s6_dmag_d, s6_dmag_q;
  logic [2:0][MAG_W+CD_LO_W-1:0]      s6_lo_d, s6_lo_q;
  logic [2:0][MAG_W+CD_HI_W-1:0]      s6_hi_d, s6_hi_q;
  logic [ROOT_W-1:0]                  s6_dist_q;
  dv_side_t                           s6_side_d, s6_side_q;

  always_comb begin
    s6_side_d.pv  = s5_side_q.pv;
    s6_side_d.hit = s5_side_q.hit;
    s6_side_d.neg = s5_side_q.neg;
    for (int i = 0; i < 3; i++) begin
      logic [DIFF_W-1:0] dabs;
      s6_side_d.dsgn[i] = s5_side_q.d[i][DIFF_W-1];
      dabs              = s6_side_d.dsgn[i] ? -s5_side_q.d[i] : s5_side_q.d[i];
      s6_dmag_d[i]      = dabs[MAG_W-1:0];
      s6_lo_d[i]        = (MAG_W + CD_LO_W)'(s6_dmag_d[i])
                        * (MAG_W + CD_LO_W)'(s5_cd_q[CD_LO_W-1:0]);
      s6_hi_d[i]        = (MAG_W + CD_HI_W)'(s6_dmag_d[i])
                        * (MAG_W + CD_HI_W)'(s5_cd_q[CD_W-1:CD_LO_W]);
    end
  end

  // stage 7: numerators of the six divisions
  logic                  s7_vld_q;
  logic [5:0][DN_W-1:0]  s7_num_d, s7_num_q;
  logic [ROOT_W-1:0]     s7_dist_q;
  dv_side_t              s7_side_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [SP_W-1:0] sp;
      sp              = SP_W'(s6_lo_q[i]) + (SP_W'(s6_hi_q[i]) << CD_LO_W);
      s7_num_d[i]     = DN_W'(sp >> (FRAC_BITS + 1));
      s7_num_d[3 + i] = DN_W'(s6_half_q) * DN_W'(s6_dmag_q[i]);
    end
  end

  logic                dd_vld;
  logic [5:0][HW-1:0]  dd_quo;
  dv_side_t            dd_side;

  spcr_div #(
    .NW    (DN_W),
    .DW    (ROOT_W),
    .QW    (HW),
    .LANES (6),
    .SW    ($bits(dv_side_t))
  ) u_vec_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s7_vld_q),
    .num_i   (s7_num_q),
    .den_i   (s7_dist_q),
    .side_i  (s7_side_q),
    .valid_o (dd_vld),
    .quo_o   (dd_quo),
    .den_o   (),
    .side_o  (dd_side)
  );

  // output stage: apply, saturate, hold both words
  res_t [1:0] res_d, res_q;
  logic       full_d, full_q;
  logic       word_d, word_q;

  always_comb begin
    res_d[0].collided = dd_side.hit;
    res_d[1].collided = dd_side.hit;
    for (int i = 0; i < 3; i++) begin
      logic signed [OW-1:0] sh, dvv;
      logic signed [OW-1:0] p1e, p2e, v1e, v2e;
      sh  = dd_side.dsgn[i] ? -OW'(dd_quo[i]) : OW'(dd_quo[i]);
      dvv = (dd_side.dsgn[i] ^ dd_side.neg) ? -OW'(dd_quo[3 + i]) : OW'(dd_quo[3 + i]);
      p1e = OW'($signed(dd_side.pv.p1[i]));
      p2e = OW'($signed(dd_side.pv.p2[i]));
      v1e = OW'($signed(dd_side.pv.v1[i]));
      v2e = OW'($signed(dd_side.pv.v2[i]));
      if (dd_side.hit) begin
        res_d[0].pos[i] = sat(p1e - sh);
        res_d[1].pos[i] = sat(p2e + sh);
        res_d[0].vel[i] = sat(v1e + dvv);
        res_d[1].vel[i] = sat(v2e - dvv);
      end else begin
        res_d[0].pos[i] = dd_side.pv.p1[i];
        res_d[1].pos[i] = dd_side.pv.p2[i];
        res_d[0].vel[i] = dd_side.pv.v1[i];
        res_d[1].vel[i] = dd_side.pv.v2[i];
      end
    end
  end

  assign adv = !full_q || (result_o.ready && word_q);

  always_comb begin
    full_d = full_q;
    word_d = word_q;
    if (adv) begin
      full_d = dd_vld;
      word_d = 1'b0;
    end else if (full_q && result_o.ready) begin
      word_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      full_q   <= 1'b0;
      word_q   <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_q <= pair_i.valid;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
        s4_vld_q <= iq_vld;
        s5_vld_q <= vd_vld;
        s6_vld_q <= s5_vld_q;
        s7_vld_q <= s6_vld_q;
      end
      full_q <= full_d;
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pv_q   <= in_pv;
      s1_d_q    <= in_d;
      s1_dv_q   <= in_dv;
      s2_sq_q   <= s2_sq_d;
      s2_pr_q   <= s2_pr_d;
      s2_nz_q   <= |s1_d_q;
      s2_pv_q   <= s1_pv_q;
      s2_d_q    <= s1_d_q;
      s3_rad_q  <= s3_rad_d;
      s3_side_q <= s3_side_d;
      s4_mag_q  <= s4_mag_d;
      s4_dist_q <= iq_root;
      s4_side_q <= s4_side_d;
      s5_cd_q   <= s5_cd_d;
      s5_hp_q   <= s5_hp_d;
      s5_dist_q <= vd_dist;
      s5_side_q <= vd_side;
      s6_half_q <= s5_hp_q[HP_W-1:FRAC_BITS+1];
      s6_dmag_q <= s6_dmag_d;
      s6_lo_q   <= s6_lo_d;
      s6_hi_q   <= s6_hi_d;
      s6_dist_q <= s5_dist_q;
      s6_side_q <= s6_side_d;
      s7_num_q  <= s7_num_d;
      s7_dist_q <= s6_dist_q;
      s7_side_q <= s6_side_q;
      res_q     <= res_d;
    end
  end

  assign pair_i.ready = adv;

  assign result_o.valid        = full_q;
  assign result_o.which_sphere = word_q;
  assign result_o.last_of_pair = word_q;
  assign result_o.collided     = res_q[word_q].collided;
  assign result_o.new_pos_x    = res_q[word_q].pos[0];
  assign result_o.new_pos_y    = res_q[word_q].pos[1];
  assign result_o.new_pos_z    = res_q[word_q].pos[2];
  assign result_o.new_vel_x    = res_q[word_q].vel[0];
  assign result_o.new_vel_y    = res_q[word_q].vel[1];
  assign result_o.new_vel_z    = res_q[word_q].vel[2];

endmodule

FILE: sv/spcr_isqrt.sv
module spcr_isqrt
  import spcr_pkg::*;
#(
  parameter int RW = 50,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RW-1:0]     rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [RW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int N = RW / 2;

  wire [N:0]             vld_w;
  wire [N:0][RW-1:0]     rem_w;
  wire [N:0][RW-1:0]     res_w;
  wire [N:0][SW-1:0]     side_w;

  assign vld_w[0]  = valid_i;
  assign rem_w[0]  = rad_i;
  assign res_w[0]  = '0;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int B = RW - 2 - 2 * k;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d, res_d, rem_q, res_q;
    logic          vld_q;
    logic [SW-1:0] side_q;

    always_comb begin
      trial = res_w[k] + (RW'(1) << B);
      if (rem_w[k] >= trial) begin
        rem_d = rem_w[k] - trial;
        res_d = (res_w[k] >> 1) + (RW'(1) << B);
      end else begin
        rem_d = rem_w[k];
        res_d = res_w[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        res_q  <= res_d;
        side_q <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld_q;
    assign rem_w[k+1]  = rem_q;
    assign res_w[k+1]  = res_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = vld_w[N];
  assign root_o  = res_w[N][N-1:0];
  assign side_o  = side_w[N];

endmodule

FILE: sv/spcr_div.sv
module spcr_div
  import spcr_pkg::*;
#(
  parameter int NW    = 50,
  parameter int DW    = 25,
  parameter int QW    = 27,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [DW-1:0]              den_o,
  output logic [SW-1:0]              side_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  wire [QW:0]                       vld_w;
  wire [QW:0][LANES-1:0][CW-1:0]    rem_w;
  wire [QW:0][LANES-1:0][QW-1:0]    quo_w;
  wire [QW:0][DW-1:0]               den_w;
  wire [QW:0][SW-1:0]               side_w;

  assign vld_w[0]  = valid_i;
  assign den_w[0]  = den_i;
  assign side_w[0] = side_i;

  for (genvar l = 0; l < LANES; l++) begin : g_lane_in
    assign rem_w[0][l] = CW'(num_i[l]);
    assign quo_w[0][l] = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int J = QW - 1 - k;
    logic [CW-1:0]                 trial;
    logic [LANES-1:0][CW-1:0]      rem_d, rem_q;
    logic [LANES-1:0][QW-1:0]      quo_d, quo_q;
    logic [DW-1:0]                 den_q;
    logic                          vld_q;
    logic [SW-1:0]                 side_q;

    always_comb begin
      trial = CW'(den_w[k]) << J;
      for (int l = 0; l < LANES; l++) begin
        if (rem_w[k][l] >= trial) begin
          rem_d[l] = rem_w[k][l] - trial;
          quo_d[l] = quo_w[k][l] | (QW'(1) << J);
        end else begin
          rem_d[l] = rem_w[k][l];
          quo_d[l] = quo_w[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        den_q  <= den_w[k];
        side_q <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld_q;
    assign rem_w[k+1]  = rem_q;
    assign quo_w[k+1]  = quo_q;
    assign den_w[k+1]  = den_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = vld_w[QW];
  assign quo_o   = quo_w[QW];
  assign den_o   = den_w[QW];
  assign side_o  = side_w[QW];

endmodule

FILE: dv/spcr_tb_pkg.sv
package spcr_tb_pkg;
  import spcr_pkg::*;

  typedef struct {
    logic                      which_sphere;
    logic                      last_of_pair;
    logic                      collided;
    logic signed [FIELD_W-1:0] pos [3];
    logic signed [FIELD_W-1:0] vel [3];
  } sphere_word_t;

  typedef struct {
    logic signed [FIELD_W-1:0] p1 [3];
    logic signed [FIELD_W-1:0] v1 [3];
    logic signed [FIELD_W-1:0] p2 [3];
    logic signed [FIELD_W-1:0] v2 [3];
  } pair_word_t;
endpackage

FILE: dv/spcr_tb_ifs.sv
interface spcr_cfg_if import spcr_pkg::*; ();
  logic                  we;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;
endinterface

FILE: dv/spcr_checker.sv
module spcr_checker
  import spcr_pkg::*;
  import spcr_tb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  spcr_cfg_if    cfg,
  spcr_in_if     pair,
  spcr_out_if    result,
  output int     fail_count,
  output int     pending_count,
  output int     hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [RADIUS_W-1:0] radius_q;
  logic [COEFF_W-1:0]  restitution_q;
  logic [COEFF_W-1:0]  correction_q;
  sphere_word_t        expected_words [$];

  function automatic longint isqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint scale_trunc(longint a, longint b, longint den);
    longint unsigned mag;
    bit neg;
    neg = (a < 0) != (b < 0);
    mag = ($unsigned(a < 0 ? -a : a) * $unsigned(b < 0 ? -b : b)) / $unsigned(den);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[FIELD_W-1:0];
  endfunction

  task automatic resolve_pair(pair_word_t w);
    sphere_word_t a, b;
    longint p1[3], v1[3], p2[3], v2[3], d[3], n1p[3], n1v[3], n2p[3], n2v[3];
    longint unsigned dist2;
    longint span, depth, cd, dotp, vn, half, sh, dv;
    bit hit;
    dist2 = 0;
    hit = 0;
    for (int i = 0; i < 3; i++) begin
      p1[i] = w.p1[i]; v1[i] = w.v1[i]; p2[i] = w.p2[i]; v2[i] = w.v2[i];
      d[i] = p2[i] - p1[i];
      dist2 += $unsigned(d[i] * d[i]);
      n1p[i] = p1[i]; n1v[i] = v1[i]; n2p[i] = p2[i]; n2v[i] = v2[i];
    end
    if (dist2 != 0) begin
      span = isqrt(dist2);
      depth = 2 * longint'(radius_q) - span;
      if (depth > 0) begin
        hit = 1;
        cd = longint'(correction_q) * depth;
        dotp = 0;
        for (int i = 0; i < 3; i++) dotp += (v2[i] - v1[i]) * d[i];
        vn = scale_trunc(dotp, 1, span);
        half = scale_trunc(vn, 65536 + longint'(restitution_q), 131072);
        for (int i = 0; i < 3; i++) begin
          sh = scale_trunc(d[i], cd, span << 17);
          dv = scale_trunc(half, d[i], span);
          n1p[i] = p1[i] - sh; n2p[i] = p2[i] + sh;
          n1v[i] = v1[i] + dv; n2v[i] = v2[i] - dv;
        end
      end
    end
    a.which_sphere = 0; a.last_of_pair = 0; a.collided = hit;
    b.which_sphere = 1; b.last_of_pair = 1; b.collided = hit;
    for (int i = 0; i < 3; i++) begin
      a.pos[i] = clamp24(n1p[i]); a.vel[i] = clamp24(n1v[i]);
      b.pos[i] = clamp24(n2p[i]); b.vel[i] = clamp24(n2v[i]);
    end
    if (hit) hit_count++;
    expected_words = {expected_words, a, b};
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_word();
    sphere_word_t e;
    string axis [3] = '{"x", "y", "z"};
    logic signed [FIELD_W-1:0] gp[3], gv[3];
    gp = '{result.new_pos_x, result.new_pos_y, result.new_pos_z};
    gv = '{result.new_vel_x, result.new_vel_y, result.new_vel_z};
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected output word", $time);
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    if (result.which_sphere !== e.which_sphere)
      report_mismatch("which_sphere", result.which_sphere, e.which_sphere);
    if (result.last_of_pair !== e.last_of_pair)
      report_mismatch("last_of_pair", result.last_of_pair, e.last_of_pair);
    if (result.collided !== e.collided)
      report_mismatch("collided", result.collided, e.collided);
    for (int i = 0; i < 3; i++) begin
      if (gp[i] !== e.pos[i]) report_mismatch({"new_pos_", axis[i]}, gp[i], e.pos[i]);
      if (gv[i] !== e.vel[i]) report_mismatch({"new_vel_", axis[i]}, gv[i], e.vel[i]);
    end
  endtask

  initial begin
    fail_count = 0;
    hit_count = 0;
    pending_count = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pair_word_t w;
    if (!rst_ni) begin
      radius_q      <= RADIUS_RST;
      restitution_q <= RESTITUTION_RST;
      correction_q  <= CORRECTION_RST;
    end else begin
      if (cfg.we) begin
        case (cfg.idx)
          CFG_RADIUS:      radius_q      <= cfg.wdata;
          CFG_RESTITUTION: restitution_q <= cfg.wdata[COEFF_W-1:0];
          CFG_CORRECTION:  correction_q  <= cfg.wdata[COEFF_W-1:0];
          default: ;
        endcase
      end
      if (pair.valid && pair.ready) begin
        w.p1 = '{pair.first_pos_x, pair.first_pos_y, pair.first_pos_z};
        w.v1 = '{pair.first_vel_x, pair.first_vel_y, pair.first_vel_z};
        w.p2 = '{pair.second_pos_x, pair.second_pos_y, pair.second_pos_z};
        w.v2 = '{pair.second_vel_x, pair.second_vel_y, pair.second_vel_z};
        resolve_pair(w);
      end
      if (result.valid && result.ready) compare_word();
    end
    pending_count = expected_words.size();
  end
endmodule

FILE: dv/testbench.sv
module testbench
  import spcr_pkg::*;
  import spcr_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 88;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending_count, hit_count;
  int   pairs_sent;
  bit   calm_phase;
  bit   hold_sink;

  spcr_cfg_if cfg ();
  spcr_in_if  pair ();
  spcr_out_if result ();

  sphere_pair_collision_resolve i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg.we),
    .cfg_idx_i   (cfg.idx),
    .cfg_wdata_i (cfg.wdata),
    .pair_i      (pair),
    .result_o    (result)
  );

  spcr_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg           (cfg),
    .pair          (pair),
    .result        (result),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .hit_count     (hit_count)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("** sphere_pair_collision_resolve: FAILED **");
    $finish;
  end

  initial begin
    int burst;
    result.ready = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        result.ready <= 0;
        repeat (400) @(posedge clk_i);
        hold_sink = 0;
      end
      burst = $urandom_range(1, 8);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        result.ready <= 0;
        repeat (burst) @(posedge clk_i);
      end else begin
        result.ready <= 1;
        repeat (burst) @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [FIELD_W-1:0] rand_field(int mode);
    case (mode)
      0: return FIELD_W'($urandom);
      1: return FIELD_W'($signed($urandom_range(0, 131072)) - 65536);
      default: return FIELD_W'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg.we    <= 1;
    cfg.idx   <= idx;
    cfg.wdata <= data;
    @(posedge clk_i);
    cfg.we    <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_pair(pair_word_t w);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      pair.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    pair.valid        <= 1;
    pair.first_pos_x  <= w.p1[0]; pair.first_pos_y  <= w.p1[1]; pair.first_pos_z  <= w.p1[2];
    pair.first_vel_x  <= w.v1[0]; pair.first_vel_y  <= w.v1[1]; pair.first_vel_z  <= w.v1[2];
    pair.second_pos_x <= w.p2[0]; pair.second_pos_y <= w.p2[1]; pair.second_pos_z <= w.p2[2];
    pair.second_vel_x <= w.v2[0]; pair.second_vel_y <= w.v2[1]; pair.second_vel_z <= w.v2[2];
    do @(posedge clk_i); while (!pair.ready);
    pairs_sent++;
  endtask

  task automatic send_random_pair();
    pair_word_t w;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      w.p1[i] = rand_field(mode < 2 ? 0 : 1);
      w.v1[i] = rand_field(mode < 4 ? 0 : 1);
      w.v2[i] = rand_field(mode < 4 ? 0 : 1);
      // most pairs sit close enough to touch
      w.p2[i] = (mode < 2) ? rand_field(0) : w.p1[i] + rand_field(mode < 5 ? 1 : 2);
    end
    if (mode == 9) w.p2 = w.p1;
    send_pair(w);
  endtask

  task automatic send_flat(logic signed [FIELD_W-1:0] a, logic signed [FIELD_W-1:0] b,
                           logic signed [FIELD_W-1:0] va, logic signed [FIELD_W-1:0] vb);
    pair_word_t w;
    for (int i = 0; i < 3; i++) begin
      w.p1[i] = a; w.p2[i] = b; w.v1[i] = va; w.v2[i] = vb;
    end
    send_pair(w);
  endtask

  task automatic drain();
    pair.valid <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    pair.valid = 0;
    {pair.first_pos_x, pair.first_pos_y, pair.first_pos_z} = '0;
    {pair.first_vel_x, pair.first_vel_y, pair.first_vel_z} = '0;
    {pair.second_pos_x, pair.second_pos_y, pair.second_pos_z} = '0;
    {pair.second_vel_x, pair.second_vel_y, pair.second_vel_z} = '0;
    cfg.we = 0; cfg.idx = CFG_RADIUS; cfg.wdata = '0;
    pairs_sent = 0; calm_phase = 0; hold_sink = 0;
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_flat(0, 0, 24'sh7FFFFF, 24'sh800000);
    send_flat(0, 100, 24'sh7FFFFF, 24'sh800000);
    send_flat(24'sh800000, 24'sh7FFFFF, 0, 0);
    send_flat(24'sh7FFFF0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_flat(24'sh800000, 24'sh800010, 24'sh7FFFFF, 24'sh800000);
    send_flat(1000, 30000, 5000, -5000);
    send_flat(-1000, -1000, 12, 12);
    send_flat(0, 1, 24'sh555555, 24'shAAAAAA);
    send_flat(0, -1, 24'shAAAAAA, 24'sh555555);
    drain();

    write_reg(CFG_RADIUS, 20'hFFFFF);
    write_reg(CFG_RESTITUTION, 20'h1FFFF);
    write_reg(CFG_CORRECTION, 20'h1FFFF);
    write_reg(cfg_idx_e'(3), 20'h0);
    send_flat(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    send_flat(0, 24'sh100000, 24'sh7FFFFF, 24'sh800000);
    send_flat(0, 3, 24'sh800000, 24'sh7FFFFF);
    drain();

    write_reg(CFG_RADIUS, '0);
    write_reg(CFG_RESTITUTION, '0);
    write_reg(CFG_CORRECTION, '0);
    send_flat(0, 1, 100, -100);
    send_flat(5, 5, 100, -100);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_RADIUS, 20'd80000);
          write_reg(CFG_RESTITUTION, 20'd65536);
          write_reg(CFG_CORRECTION, 20'd65536);
        end
        1: begin
          write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(0, 524288)));
          write_reg(CFG_RESTITUTION, CFG_DATA_W'($urandom_range(0, 65536)));
          write_reg(CFG_CORRECTION, CFG_DATA_W'($urandom_range(0, 65536)));
        end
        2: begin
          write_reg(CFG_RADIUS, 20'd524288);
          write_reg(CFG_RESTITUTION, 20'd62259);
          write_reg(CFG_CORRECTION, 20'd13107);
        end
        3: begin
          write_reg(CFG_RADIUS, CFG_DATA_W'($urandom));
          write_reg(CFG_RESTITUTION, CFG_DATA_W'($urandom));
          write_reg(CFG_CORRECTION, CFG_DATA_W'($urandom));
        end
        default: begin
          write_reg(CFG_RADIUS, 20'd65536);
          write_reg(CFG_RESTITUTION, 20'd32768);
          write_reg(CFG_CORRECTION, 20'd65536);
        end
      endcase
      if (phase == 2) hold_sink = 1;
      if (phase == 4) calm_phase = 1;
      repeat (100) send_random_pair();
      drain();
    end

    $display("sent %0d sphere pairs over eight register settings, %0d collided",
             pairs_sent, hit_count);
    if (fail_count == 0) begin
      $display("** sphere_pair_collision_resolve: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** sphere_pair_collision_resolve: FAILED **");
    end
    $finish;
  end
endmodule
